// ----- rtl/core/dram_bank_page_policy_macros.svh -----
// Assertion macros for the DRAM bank page-policy block.
// Bodies sample on clk and are disabled while rst is high; no other dependencies.
`ifndef DRAM_BANK_PAGE_POLICY_MACROS_SVH
`define DRAM_BANK_PAGE_POLICY_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define BPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bank page policy: next-cycle check failed");

// Consequent must hold in the same cycle as the antecedent.
`define BPP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bank page policy: same-cycle check failed");

`endif

// ----- rtl/core/bpp_pkg.sv -----
// Shared types and codes for the DRAM bank page-policy block.
// No dependencies; used by bpp_decide, bpp_result_queue and dram_bank_page_policy.
`timescale 1ns / 1ps

package bpp_pkg;

  typedef enum logic [1:0] {
    OP_EVAL   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_BLOCK  = 2'd2
  } bpp_op_t;

  typedef enum logic [3:0] {
    ISS_ACT     = 4'd0,
    ISS_PRE     = 4'd1,
    ISS_RD      = 4'd2,
    ISS_WR      = 4'd3,
    ISS_RDA     = 4'd4,
    ISS_WRA     = 4'd5,
    ISS_PD_SREF = 4'd6,
    ISS_REF     = 4'd7,
    ISS_RFM     = 4'd8,
    ISS_PD_EXIT = 4'd9,
    ISS_OTHER   = 4'd10
  } bpp_issued_t;

  typedef enum logic [2:0] {
    CMD_NOP = 3'd0,
    CMD_ACT = 3'd1,
    CMD_PRE = 3'd2,
    CMD_RD  = 3'd3,
    CMD_WR  = 3'd4,
    CMD_RDA = 3'd5,
    CMD_WRA = 3'd6
  } bpp_cmd_t;

  typedef enum logic [1:0] {
    POL_OPEN         = 2'd0,
    POL_CLOSED       = 2'd1,
    POL_OPEN_ADAPT   = 2'd2,
    POL_CLOSED_ADAPT = 2'd3
  } bpp_policy_t;

  typedef enum logic [1:0] {
    REG_PAGE_POLICY  = 2'd0,
    REG_RM_ENABLE    = 2'd1,
    REG_DEC_REFRESH  = 2'd2,
    REG_DEC_RFM      = 2'd3
  } bpp_reg_t;

  typedef struct packed {
    logic row_is_open;
    logic held_valid;
    logic held_write;
    logic keep_held;
    logic asleep;
    logic stalled;
  } bpp_flags_t;

  typedef struct packed {
    bpp_cmd_t    next_cmd;
    logic        bank_idle;
    logic        bank_activated;
    logic [15:0] row_open_now;
    logic [15:0] activation_count;
  } bpp_result_t;

  typedef struct packed {
    bpp_policy_t page_policy;
    logic        refresh_mgmt_enable;
    logic [15:0] decrement_on_refresh;
    logic [15:0] decrement_on_rfm;
  } bpp_cfg_t;

endpackage

// ----- rtl/core/bpp_decide.sv -----
// Next-state and command selection for one bank transaction.
// Depends on bpp_pkg; purely combinational, state lives in the top level.
`timescale 1ns / 1ps

module bpp_decide #(
  parameter int ROW_BITS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  bpp_pkg::bpp_cfg_t    cfg,
  input  bpp_pkg::bpp_flags_t  flags,
  input  logic [ROW_BITS-1:0]  open_row,
  input  logic [ROW_BITS-1:0]  held_row,
  input  logic [COUNT_BITS-1:0] act_counter,
  input  bpp_pkg::bpp_cmd_t    chosen_cmd,
  input  logic [1:0]           op,
  input  logic                 req_valid,
  input  logic [ROW_BITS-1:0]  req_row,
  input  logic                 req_is_write,
  input  logic                 further_request,
  input  logic                 further_row_hit,
  input  logic [3:0]           issued_cmd,
  output bpp_pkg::bpp_flags_t  flags_next,
  output logic [ROW_BITS-1:0]  open_row_next,
  output logic [ROW_BITS-1:0]  held_row_next,
  output logic [COUNT_BITS-1:0] act_counter_next,
  output bpp_pkg::bpp_cmd_t    chosen_cmd_next
);
  import bpp_pkg::*;

  localparam int SUB_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic             auto_pre;
  logic [15:0]      dec_amt;
  logic [SUB_W-1:0] cnt_ext;
  logic [SUB_W-1:0] dec_ext;
  logic [SUB_W-1:0] cnt_diff;
  logic [COUNT_BITS-1:0] cnt_floored;
  logic [COUNT_BITS-1:0] cnt_incr;

  // one shared floor-at-zero subtractor for REF and RFM
  always_comb begin
    dec_amt  = (issued_cmd == ISS_RFM) ? cfg.decrement_on_rfm : cfg.decrement_on_refresh;
    cnt_ext  = SUB_W'(act_counter);
    dec_ext  = SUB_W'(dec_amt);
    cnt_diff = cnt_ext - dec_ext;
    cnt_floored = (cnt_ext > dec_ext) ? COUNT_BITS'(cnt_diff) : '0;
    cnt_incr = (act_counter != {COUNT_BITS{1'b1}}) ? act_counter + COUNT_BITS'(1)
                                                   : act_counter;
  end

  always_comb begin
    flags_next       = flags;
    open_row_next    = open_row;
    held_row_next    = held_row;
    act_counter_next = act_counter;
    chosen_cmd_next  = chosen_cmd;
    auto_pre         = 1'b0;
    case (op)
      OP_EVAL: begin
        chosen_cmd_next = CMD_NOP;
        if (!flags.asleep && !flags.stalled && req_valid) begin
          // a kept request is only replaced by a hit to the open row
          if (!flags.keep_held || req_row == open_row) begin
            flags_next.held_valid = 1'b1;
            flags_next.held_write = req_is_write;
            held_row_next         = req_row;
          end
          case (cfg.page_policy)
            POL_OPEN:         auto_pre = 1'b0;
            POL_OPEN_ADAPT:   auto_pre = further_request && !further_row_hit;
            POL_CLOSED_ADAPT: auto_pre = !further_row_hit;
            default:          auto_pre = 1'b1;
          endcase
          if (!flags.row_is_open) begin
            chosen_cmd_next = CMD_ACT;
          end else if (cfg.page_policy != POL_CLOSED && held_row_next != open_row) begin
            chosen_cmd_next = CMD_PRE;
          end else if (auto_pre) begin
            chosen_cmd_next = flags_next.held_write ? CMD_WRA : CMD_RDA;
          end else begin
            chosen_cmd_next = flags_next.held_write ? CMD_WR : CMD_RD;
          end
        end
      end
      OP_UPDATE: begin
        case (issued_cmd)
          ISS_ACT: begin
            flags_next.row_is_open = 1'b1;
            flags_next.keep_held   = 1'b1;
            open_row_next          = held_row;
            act_counter_next       = cnt_incr;
          end
          ISS_PRE: begin
            flags_next.row_is_open = 1'b0;
            flags_next.keep_held   = 1'b0;
          end
          ISS_RD, ISS_WR: begin
            flags_next.held_valid = 1'b0;
            flags_next.keep_held  = 1'b0;
          end
          ISS_RDA, ISS_WRA: begin
            flags_next.row_is_open = 1'b0;
            flags_next.held_valid  = 1'b0;
            flags_next.keep_held   = 1'b0;
          end
          ISS_PD_SREF: flags_next.asleep = 1'b1;
          ISS_REF, ISS_RFM: begin
            flags_next.asleep  = 1'b0;
            flags_next.stalled = 1'b0;
            if (cfg.refresh_mgmt_enable) begin
              act_counter_next = cnt_floored;
            end
          end
          ISS_PD_EXIT: flags_next.asleep = 1'b0;
          default: ;
        endcase
      end
      OP_BLOCK: begin
        flags_next.stalled = 1'b1;
        chosen_cmd_next    = CMD_NOP;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/bpp_result_queue.sv -----
// Two-entry result queue between the bank logic and the output channel.
// Depends on bpp_pkg for the result type.
`timescale 1ns / 1ps

module bpp_result_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bpp_pkg::bpp_result_t push_data,
  input  logic                 pop,
  output logic                 full,
  output logic                 valid,
  output bpp_pkg::bpp_result_t head
);
  import bpp_pkg::*;

  bpp_result_t entry [2];
  logic [1:0]  count;
  logic        wr_ptr;
  logic        rd_ptr;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

// ----- rtl/core/dram_bank_page_policy.sv -----
// Latency: out_valid is high in the cycle after a transaction is accepted; its own result may wait behind earlier ones.
// Throughput: one transaction per cycle; bank state updates at the accepting edge,
// results wait in a two-entry queue, so input stalls only when that queue is full.
// Config writes are taken every cycle. Reset clears bank state, config and queue.
// Depends on bpp_pkg, bpp_decide, bpp_result_queue and the assertion macro header.
`timescale 1ns / 1ps

module dram_bank_page_policy #(
  parameter int ROW_BITS   = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic        req_valid,
  input  logic [15:0] req_row,
  input  logic        req_is_write,
  input  logic        further_request,
  input  logic        further_row_hit,
  input  logic [3:0]  issued_cmd,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  next_cmd,
  output logic        bank_idle,
  output logic        bank_activated,
  output logic [15:0] row_open_now,
  output logic [15:0] activation_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import bpp_pkg::*;

  `include "dram_bank_page_policy_macros.svh"

  bpp_cfg_t              cfg;
  bpp_flags_t            flags;
  bpp_flags_t            flags_next;
  logic [ROW_BITS-1:0]   open_row;
  logic [ROW_BITS-1:0]   open_row_next;
  logic [ROW_BITS-1:0]   held_row;
  logic [ROW_BITS-1:0]   held_row_next;
  logic [COUNT_BITS-1:0] act_counter;
  logic [COUNT_BITS-1:0] act_counter_next;
  bpp_cmd_t              chosen_cmd;
  bpp_cmd_t              chosen_cmd_next;
  logic                  in_fire;
  logic                  q_full;
  bpp_result_t           result;
  bpp_result_t           q_head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAGE_POLICY: cfg.page_policy          <= bpp_policy_t'(cfg_data[1:0]);
        REG_RM_ENABLE:   cfg.refresh_mgmt_enable  <= cfg_data[0];
        REG_DEC_REFRESH: cfg.decrement_on_refresh <= cfg_data;
        REG_DEC_RFM:     cfg.decrement_on_rfm     <= cfg_data;
        default: ;
      endcase
    end
  end

  bpp_decide #(
    .ROW_BITS  (ROW_BITS),
    .COUNT_BITS(COUNT_BITS)
  ) u_decide (
    .cfg             (cfg),
    .flags           (flags),
    .open_row        (open_row),
    .held_row        (held_row),
    .act_counter     (act_counter),
    .chosen_cmd      (chosen_cmd),
    .op              (op),
    .req_valid       (req_valid),
    .req_row         (ROW_BITS'(req_row)),
    .req_is_write    (req_is_write),
    .further_request (further_request),
    .further_row_hit (further_row_hit),
    .issued_cmd      (issued_cmd),
    .flags_next      (flags_next),
    .open_row_next   (open_row_next),
    .held_row_next   (held_row_next),
    .act_counter_next(act_counter_next),
    .chosen_cmd_next (chosen_cmd_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags       <= '0;
      open_row    <= '0;
      held_row    <= '0;
      act_counter <= '0;
      chosen_cmd  <= CMD_NOP;
    end else if (in_fire) begin
      flags       <= flags_next;
      open_row    <= open_row_next;
      held_row    <= held_row_next;
      act_counter <= act_counter_next;
      chosen_cmd  <= chosen_cmd_next;
    end
  end

  // result reports the state after this transaction
  always_comb begin
    result.next_cmd         = chosen_cmd_next;
    result.bank_idle        = !flags_next.held_valid;
    result.bank_activated   = flags_next.row_is_open;
    result.row_open_now     = 16'(open_row_next);
    result.activation_count = 16'(act_counter_next);
  end

  bpp_result_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (in_fire),
    .push_data(result),
    .pop      (out_valid && out_ready),
    .full     (q_full),
    .valid    (out_valid),
    .head     (q_head)
  );

  assign next_cmd         = q_head.next_cmd;
  assign bank_idle        = q_head.bank_idle;
  assign bank_activated   = q_head.bank_activated;
  assign row_open_now     = q_head.row_open_now;
  assign activation_count = q_head.activation_count;

  `BPP_ASSERT_NEXT(a_result_follows, in_fire, out_valid)
  `BPP_ASSERT_NEXT(a_stalled_eval_nop, in_fire && flags.stalled && op == OP_EVAL, chosen_cmd == CMD_NOP)
  `BPP_ASSERT_NEXT(a_act_opens_row, in_fire && op == OP_UPDATE && issued_cmd == ISS_ACT, flags.row_is_open && flags.keep_held)
  `BPP_ASSERT_NOW(a_ready_tracks_queue, q_full, !in_ready)

endmodule
